@@ rtl/core/dtv_pkg.sv @@
// shared constants, widths and lookup functions for the date/time validator
package dtv_pkg;

  localparam int unsigned YEAR_W    = 10;
  localparam int unsigned MONTH_W   = 4;
  localparam int unsigned DAY_W     = 6;
  localparam int unsigned HOUR_W    = 5;
  localparam int unsigned MINUTE_W  = 6;
  localparam int unsigned SECOND_W  = 6;
  localparam int unsigned WDAY_W    = 3;
  localparam int unsigned MLEN_W    = 5;
  localparam int unsigned FULLY_W   = 12;

  localparam logic [FULLY_W-1:0]  YEAR_BASE    = 12'd1900;
  localparam logic [YEAR_W-1:0]   YEAR_OFS_MIN = 10'd100;
  localparam logic [YEAR_W-1:0]   YEAR_OFS_MAX = 10'd200;
  localparam logic [HOUR_W-1:0]   HOUR_MAX     = 5'd23;
  localparam logic [MINUTE_W-1:0] MINUTE_MAX   = 6'd59;
  localparam logic [SECOND_W-1:0] SECOND_MAX   = 6'd60;
  localparam logic [WDAY_W-1:0]   WEEKDAY_NONE = 3'd7;
  localparam logic [WDAY_W-1:0]   WEEKDAY_SUN  = 3'd6;
  localparam logic [MONTH_W-1:0]  MONTH_FEB    = 4'd1;
  localparam logic [MONTH_W-1:0]  MONTH_DEC    = 4'd11;

  // floor(x / 100) == (x * 5243) >> 19 for x below 4096
  localparam logic [12:0] DIV100_RECIP = 13'd5243;
  localparam int unsigned DIV100_SHIFT = 19;

  // days in month by zero-based month index, 0 for codes past december
  function automatic logic [MLEN_W-1:0] base_month_len(input logic [MONTH_W-1:0] mon);
    logic [MLEN_W-1:0] len;
    case (mon)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
      4'd3, 4'd5, 4'd8, 4'd10:                   len = 5'd30;
      4'd1:                                      len = 5'd28;
      default:                                   len = 5'd0;
    endcase
    return len;
  endfunction

  // floor(3 * (m + 1) / 5) for the shifted month 3..14
  function automatic logic [3:0] month_term(input logic [MONTH_W-1:0] m);
    logic [3:0] t;
    case (m)
      4'd3:         t = 4'd2;
      4'd4, 4'd5:   t = 4'd3;
      4'd6, 4'd7:   t = 4'd4;
      4'd8:         t = 4'd5;
      4'd9, 4'd10:  t = 4'd6;
      4'd11, 4'd12: t = 4'd7;
      4'd13:        t = 4'd8;
      4'd14:        t = 4'd9;
      default:      t = 4'd0;
    endcase
    return t;
  endfunction

endpackage

@@ rtl/core/dtv_in_if.sv @@
// input channel: one broken-down time per transaction
interface dtv_in_if;
  logic                           valid;
  logic                           ready;
  logic [dtv_pkg::YEAR_W-1:0]     years_since_1900;
  logic [dtv_pkg::MONTH_W-1:0]    month_index;
  logic [dtv_pkg::DAY_W-1:0]      day_value;
  logic [dtv_pkg::HOUR_W-1:0]     hour_value;
  logic [dtv_pkg::MINUTE_W-1:0]   minute_value;
  logic [dtv_pkg::SECOND_W-1:0]   second_value;
  logic [dtv_pkg::WDAY_W-1:0]     given_weekday;

  modport source (output valid, years_since_1900, month_index, day_value, hour_value,
                  minute_value, second_value, given_weekday, input ready);
  modport sink (input valid, years_since_1900, month_index, day_value, hour_value,
                minute_value, second_value, given_weekday, output ready);
endinterface

@@ rtl/core/dtv_out_if.sv @@
// output channel: validity, weekday and month length per transaction
interface dtv_out_if;
  logic                           valid;
  logic                           ready;
  logic                           time_valid;
  logic [dtv_pkg::WDAY_W-1:0]     computed_weekday;
  logic [dtv_pkg::MLEN_W-1:0]     month_length;

  modport source (output valid, time_valid, computed_weekday, month_length, input ready);
  modport sink (input valid, time_valid, computed_weekday, month_length, output ready);
endinterface

@@ rtl/core/date_time_validator_weekday_core.sv @@
// Checks a broken-down calendar time and computes its weekday and month length.
// din carries one time per transaction: years since 1900, month 0-11, day, hour,
// minute, second and a claimed weekday (0 = Sunday, 7 = not given). dout returns
// time_valid, the weekday by the Kim Larsen formula (0 = Monday) and the number
// of days in the month (0 for a bad month code).
// The work runs through four register stages: input decode, constant-reciprocal
// quotients, weekday sum and leap rule, then mod-7 fold and checks. The result
// is held on dout until taken; one transaction is taken every cycle while dout
// is ready, since then every stage moves each cycle.
// Each stage holds a valid bit and moves on when the stage after it is empty
// or moving, so bubbles are squeezed out and a stalled dout only backs up the
// stages that are full; din.ready drops once all four hold items while dout stalls.
// Synchronous reset clears the valid bits; no result is pending afterwards.
module date_time_validator_weekday_core (
  input logic       clk,
  input logic       rst,
  dtv_in_if.sink    din,
  dtv_out_if.source dout
);
  import dtv_pkg::*;

  logic v1, v2, v3, v4;
  logic adv1, adv2, adv3, adv4;

  // stage 1 registers
  logic                  s1_mon_ok;
  logic                  s1_range_ok;
  logic [MONTH_W-1:0]    s1_mon;
  logic [MONTH_W-1:0]    s1_madj;
  logic [DAY_W-1:0]      s1_day;
  logic [FULLY_W-1:0]    s1_year;
  logic [FULLY_W-1:0]    s1_yadj;
  logic                  s1_given;
  logic [WDAY_W-1:0]     s1_claimed;

  // stage 2 registers
  logic                  s2_mon_ok;
  logic                  s2_range_ok;
  logic [MONTH_W-1:0]    s2_mon;
  logic [DAY_W-1:0]      s2_day;
  logic [FULLY_W-1:0]    s2_year;
  logic [FULLY_W-1:0]    s2_partial;
  logic [4:0]            s2_q100;
  logic [2:0]            s2_q400;
  logic [4:0]            s2_yq100;
  logic [2:0]            s2_yq400;
  logic                  s2_given;
  logic [WDAY_W-1:0]     s2_claimed;

  // stage 3 registers
  logic                  s3_mon_ok;
  logic                  s3_range_ok;
  logic [DAY_W-1:0]      s3_day;
  logic [FULLY_W-1:0]    s3_sum;
  logic [MLEN_W-1:0]     s3_mlen;
  logic                  s3_given;
  logic [WDAY_W-1:0]     s3_claimed;

  // output registers
  logic                  time_valid;
  logic [WDAY_W-1:0]     computed_weekday;
  logic [MLEN_W-1:0]     month_length;

  assign adv4 = !v4 || dout.ready;
  assign adv3 = !v3 || adv4;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign din.ready = adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (adv1) v1 <= din.valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) v4 <= v3;
    end
  end

  // stage 1: decode fields, shift january and february into the previous year
  logic                  c1_early;
  logic [FULLY_W-1:0]    c1_year;

  always_comb begin
    c1_early = din.month_index <= MONTH_FEB;
    c1_year  = {{(FULLY_W-YEAR_W){1'b0}}, din.years_since_1900} + YEAR_BASE;
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_mon_ok   <= din.month_index <= MONTH_DEC;
      s1_range_ok <= din.years_since_1900 >= YEAR_OFS_MIN
                  && din.years_since_1900 <= YEAR_OFS_MAX
                  && din.hour_value <= HOUR_MAX
                  && din.minute_value <= MINUTE_MAX
                  && din.second_value <= SECOND_MAX;
      s1_mon      <= din.month_index;
      s1_madj     <= c1_early ? din.month_index + 4'd13 : din.month_index + 4'd1;
      s1_day      <= din.day_value;
      s1_year     <= c1_year;
      s1_yadj     <= c1_year - {{(FULLY_W-1){1'b0}}, c1_early};
      s1_given    <= din.given_weekday != WEEKDAY_NONE;
      s1_claimed  <= (din.given_weekday == 3'd0) ? WEEKDAY_SUN
                                                 : din.given_weekday - 3'd1;
    end
  end

  // stage 2: quotients by 100 and 400 through reciprocal multiplies
  logic [24:0]           p_q100, p_q400, p_yq100, p_yq400;
  logic [FULLY_W-1:0]    c2_partial;

  always_comb begin
    p_q100  = {13'b0, s1_yadj} * {12'b0, DIV100_RECIP};
    p_q400  = {15'b0, s1_yadj[FULLY_W-1:2]} * {12'b0, DIV100_RECIP};
    p_yq100 = {13'b0, s1_year} * {12'b0, DIV100_RECIP};
    p_yq400 = {15'b0, s1_year[FULLY_W-1:2]} * {12'b0, DIV100_RECIP};
    c2_partial = {{(FULLY_W-DAY_W){1'b0}}, s1_day}
               + {{(FULLY_W-MONTH_W-1){1'b0}}, s1_madj, 1'b0}
               + {8'b0, month_term(s1_madj)}
               + s1_yadj
               + {2'b0, s1_yadj[FULLY_W-1:2]};
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_mon_ok   <= s1_mon_ok;
      s2_range_ok <= s1_range_ok;
      s2_mon      <= s1_mon;
      s2_day      <= s1_day;
      s2_year     <= s1_year;
      s2_partial  <= c2_partial;
      s2_q100     <= p_q100[DIV100_SHIFT+4:DIV100_SHIFT];
      s2_q400     <= p_q400[DIV100_SHIFT+2:DIV100_SHIFT];
      s2_yq100    <= p_yq100[DIV100_SHIFT+4:DIV100_SHIFT];
      s2_yq400    <= p_yq400[DIV100_SHIFT+2:DIV100_SHIFT];
      s2_given    <= s1_given;
      s2_claimed  <= s1_claimed;
    end
  end

  // stage 3: finish the weekday sum, apply the gregorian leap rule
  logic                  c3_leap;
  logic [MLEN_W-1:0]     c3_mlen;
  logic [FULLY_W-1:0]    c3_cent, c3_quad;

  always_comb begin
    c3_cent = {7'b0, s2_yq100} * 12'd100;
    c3_quad = {9'b0, s2_yq400} * 12'd400;
    c3_leap = (s2_year[1:0] == 2'b00 && c3_cent != s2_year) || c3_quad == s2_year;
    if (s2_mon == MONTH_FEB && c3_leap) begin
      c3_mlen = 5'd29;
    end else begin
      c3_mlen = base_month_len(s2_mon);
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      s3_mon_ok   <= s2_mon_ok;
      s3_range_ok <= s2_range_ok;
      s3_day      <= s2_day;
      s3_sum      <= s2_partial - {7'b0, s2_q100} + {9'b0, s2_q400};
      s3_mlen     <= c3_mlen;
      s3_given    <= s2_given;
      s3_claimed  <= s2_claimed;
    end
  end

  // stage 4: mod 7 by folding octal digits, since 8 is 1 mod 7
  logic [4:0]            c4_fold1;
  logic [3:0]            c4_fold2;
  logic [WDAY_W-1:0]     c4_wd;
  logic                  c4_ok;

  always_comb begin
    c4_fold1 = {2'b0, s3_sum[2:0]} + {2'b0, s3_sum[5:3]}
             + {2'b0, s3_sum[8:6]} + {2'b0, s3_sum[11:9]};
    c4_fold2 = {1'b0, c4_fold1[2:0]} + {2'b0, c4_fold1[4:3]};
    c4_wd    = (c4_fold2 >= 4'd7) ? 3'(c4_fold2 - 4'd7) : c4_fold2[2:0];
    c4_ok    = s3_mon_ok && s3_range_ok
            && s3_day != '0 && {1'b0, s3_mlen} >= s3_day
            && (!s3_given || s3_claimed == c4_wd);
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      time_valid       <= c4_ok;
      computed_weekday <= s3_mon_ok ? c4_wd : '0;
      month_length     <= s3_mlen;
    end
  end

  assign dout.valid            = v4;
  assign dout.time_valid       = time_valid;
  assign dout.computed_weekday = computed_weekday;
  assign dout.month_length     = month_length;

  a_wd_range: assert property (@(posedge clk) disable iff (rst)
    v4 |-> computed_weekday <= WEEKDAY_SUN)
    else $error("weekday out of range");

  a_bad_month: assert property (@(posedge clk) disable iff (rst)
    v4 && month_length == '0 |-> !time_valid && computed_weekday == '0)
    else $error("bad month reported as valid or with a weekday");

  a_valid_len: assert property (@(posedge clk) disable iff (rst)
    v4 && time_valid |-> month_length >= 5'd28)
    else $error("valid time with short month length");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    v1 && adv2 |=> v2)
    else $error("item lost between stage 1 and stage 2");

endmodule

@@ verif/date_time_validator_weekday_core_test.sv @@
// self-checking testbench for the date/time validator with weekday computation
`timescale 1ns / 1ps

module date_time_validator_weekday_core_test;
  import dtv_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned IDLE_PERCENT = 14;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [YEAR_W-1:0]   years_since_1900;
    logic [MONTH_W-1:0]  month_index;
    logic [DAY_W-1:0]    day_value;
    logic [HOUR_W-1:0]   hour_value;
    logic [MINUTE_W-1:0] minute_value;
    logic [SECOND_W-1:0] second_value;
    logic [WDAY_W-1:0]   given_weekday;
  } time_fields_t;

  typedef struct packed {
    logic              time_valid;
    logic [WDAY_W-1:0] computed_weekday;
    logic [MLEN_W-1:0] month_length;
  } verdict_t;

  typedef enum int unsigned {
    BAD_YEAR, BAD_MONTH, BAD_DAY, BAD_HOUR, BAD_MINUTE, BAD_SECOND
  } bad_field_e;

  localparam int unsigned NORMAL_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  logic clk = 1'b0;
  logic rst;
  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  bit gaps_on = 1'b1;
  verdict_t expected_verdicts [$];

  dtv_in_if din_bus ();
  dtv_out_if dout_bus ();

  date_time_validator_weekday_core dut (
    .clk  (clk),
    .rst  (rst),
    .din  (din_bus),
    .dout (dout_bus)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("date_time_validator_weekday_core_test NOT OK");
      $finish;
    end
  end

  // sink side back-pressure
  always @(posedge clk) begin
    dout_bus.ready <= !gaps_on || ($urandom_range(99) >= IDLE_PERCENT);
  end

  // expected weekday, month length and validity of one broken-down time
  function automatic verdict_t predict_verdict(input time_fields_t t);
    verdict_t v;
    int unsigned full_year, adj_year, adj_month, weekday, claimed;
    bit leap, ok;
    v = '0;
    full_year = t.years_since_1900 + 1900;
    if (t.month_index <= MONTH_DEC) begin
      leap = ((full_year % 4 == 0) && (full_year % 100 != 0)) || (full_year % 400 == 0);
      v.month_length = MLEN_W'((t.month_index == MONTH_FEB && leap) ? 29
                                                                    : NORMAL_DAYS[t.month_index]);
      // january and february count as months 13 and 14 of the year before
      adj_month = t.month_index + 1;
      adj_year = full_year;
      if (adj_month <= 2) begin
        adj_month += 12;
        adj_year -= 1;
      end
      weekday = (t.day_value + 2 * adj_month + (3 * (adj_month + 1)) / 5 + adj_year
                 + adj_year / 4 - adj_year / 100 + adj_year / 400) % 7;
      v.computed_weekday = WDAY_W'(weekday);
    end
    ok = (t.month_index <= MONTH_DEC)
      && (t.years_since_1900 >= YEAR_OFS_MIN) && (t.years_since_1900 <= YEAR_OFS_MAX)
      && (t.hour_value <= HOUR_MAX) && (t.minute_value <= MINUTE_MAX)
      && (t.second_value <= SECOND_MAX)
      && (t.day_value >= 1) && (t.day_value <= v.month_length);
    if (ok && t.given_weekday != WEEKDAY_NONE) begin
      // claims count from sunday, the formula from monday
      claimed = (t.given_weekday > 0) ? t.given_weekday - 1 : WEEKDAY_SUN;
      if (claimed != v.computed_weekday) ok = 1'b0;
    end
    v.time_valid = ok;
    return v;
  endfunction

  function automatic time_fields_t make_time(input int unsigned yofs, mon, day, hr, mins, secs,
                                             wday);
    time_fields_t t;
    t.years_since_1900 = YEAR_W'(yofs);
    t.month_index = MONTH_W'(mon);
    t.day_value = DAY_W'(day);
    t.hour_value = HOUR_W'(hr);
    t.minute_value = MINUTE_W'(mins);
    t.second_value = SECOND_W'(secs);
    t.given_weekday = WDAY_W'(wday);
    return t;
  endfunction

  // sunday-based claim that agrees with the computed weekday
  function automatic logic [WDAY_W-1:0] claim_for(input time_fields_t t);
    verdict_t v;
    v = predict_verdict(t);
    return (v.computed_weekday == WEEKDAY_SUN) ? '0 : v.computed_weekday + 1'b1;
  endfunction

  function automatic logic [WDAY_W-1:0] wrong_claim_for(input time_fields_t t);
    logic [WDAY_W-1:0] c;
    c = claim_for(t);
    return (c == 3'd6) ? '0 : c + 1'b1;
  endfunction

  task automatic note_mismatch(input string what);
    if (mismatch_count < MAX_REPORTS) $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : result_checker
    verdict_t want;
    if (!rst && dout_bus.valid && dout_bus.ready) begin
      if (expected_verdicts.size() == 0) begin
        note_mismatch("result with no transaction outstanding");
      end else begin
        want = expected_verdicts.pop_front();
        if (dout_bus.time_valid !== want.time_valid)
          note_mismatch($sformatf("time_valid expected %0d got %0d",
                                  want.time_valid, dout_bus.time_valid));
        if (dout_bus.computed_weekday !== want.computed_weekday)
          note_mismatch($sformatf("computed_weekday expected %0d got %0d",
                                  want.computed_weekday, dout_bus.computed_weekday));
        if (dout_bus.month_length !== want.month_length)
          note_mismatch($sformatf("month_length expected %0d got %0d",
                                  want.month_length, dout_bus.month_length));
      end
    end
  end

  // valid stays high across back-to-back transactions
  task automatic send_time(input time_fields_t t);
    while (gaps_on && ($urandom_range(99) < IDLE_PERCENT)) begin
      din_bus.valid <= 1'b0;
      @(posedge clk);
    end
    din_bus.valid <= 1'b1;
    din_bus.years_since_1900 <= t.years_since_1900;
    din_bus.month_index <= t.month_index;
    din_bus.day_value <= t.day_value;
    din_bus.hour_value <= t.hour_value;
    din_bus.minute_value <= t.minute_value;
    din_bus.second_value <= t.second_value;
    din_bus.given_weekday <= t.given_weekday;
    @(posedge clk);
    while (!din_bus.ready) @(posedge clk);
    expected_verdicts.push_back(predict_verdict(t));
  endtask

  task automatic drain_results();
    din_bus.valid <= 1'b0;
    @(posedge clk);
    while (expected_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic test_field_extremes();
    send_time(make_time(0, 0, 0, 0, 0, 0, 0));
    send_time(make_time(1023, 15, 63, 31, 63, 63, 7));
    send_time(make_time(100, 0, 1, 0, 0, 0, 7));
    send_time(make_time(200, 11, 31, 23, 59, 60, 7));
    send_time(make_time(99, 5, 10, 12, 30, 30, 7));
    send_time(make_time(201, 5, 10, 12, 30, 30, 7));
    send_time(make_time(1023, 5, 10, 12, 30, 30, 7));
    send_time(make_time(150, 12, 10, 12, 30, 30, 7));
    send_time(make_time(150, 3, 10, 24, 30, 30, 7));
    send_time(make_time(150, 3, 10, 12, 60, 30, 7));
    send_time(make_time(150, 3, 10, 12, 30, 61, 7));
  endtask

  task automatic test_calendar_rules();
    time_fields_t t;
    send_time(make_time(100, 1, 29, 8, 0, 0, 7));   // 2000 is a leap year
    send_time(make_time(200, 1, 29, 8, 0, 0, 7));   // 2100 is not
    send_time(make_time(200, 1, 28, 8, 0, 0, 7));
    send_time(make_time(124, 1, 29, 8, 0, 0, 7));
    send_time(make_time(123, 1, 29, 8, 0, 0, 7));
    send_time(make_time(124, 4, 0, 8, 0, 0, 7));
    send_time(make_time(124, 0, 32, 8, 0, 0, 7));
    send_time(make_time(124, 3, 31, 8, 0, 0, 7));
    send_time(make_time(124, 0, 7, 8, 0, 0, 0));    // a sunday claimed as sunday
    send_time(make_time(124, 0, 8, 8, 0, 0, 0));    // a monday claimed as sunday
    t = make_time(137, 6, 19, 17, 45, 5, 7);
    t.given_weekday = claim_for(t);
    send_time(t);
    t.given_weekday = wrong_claim_for(t);
    send_time(t);
    t = make_time(137, 6, 19, 25, 45, 5, 7);
    t.given_weekday = claim_for(t);
    send_time(t);
  endtask

  task automatic test_random_times(input int unsigned count);
    time_fields_t t;
    verdict_t v;
    int unsigned roll;
    repeat (count) begin
      roll = $urandom_range(99);
      if (roll < 15) begin
        t = make_time($urandom_range(1023), $urandom_range(15), $urandom_range(63),
                      $urandom_range(31), $urandom_range(63), $urandom_range(63),
                      $urandom_range(7));
      end else begin
        t = make_time($urandom_range(200, 100), $urandom_range(11), 1, $urandom_range(23),
                      $urandom_range(59), $urandom_range(60), 7);
        v = predict_verdict(t);
        t.day_value = DAY_W'($urandom_range(v.month_length, 1));
        roll = $urandom_range(99);
        if (roll < 50) t.given_weekday = claim_for(t);
        else if (roll < 80) t.given_weekday = WDAY_W'($urandom_range(6));
        if ($urandom_range(99) < 15) begin
          case (bad_field_e'($urandom_range(5)))
            BAD_YEAR:   t.years_since_1900 = YEAR_W'($urandom_range(1) ? $urandom_range(99)
                                                     : $urandom_range(1023, 201));
            BAD_MONTH:  t.month_index = MONTH_W'($urandom_range(15, 12));
            BAD_DAY:    t.day_value = DAY_W'($urandom_range(1) ? 0
                                             : $urandom_range(63, v.month_length + 1));
            BAD_HOUR:   t.hour_value = HOUR_W'($urandom_range(31, 24));
            BAD_MINUTE: t.minute_value = MINUTE_W'($urandom_range(63, 60));
            BAD_SECOND: t.second_value = SECOND_W'($urandom_range(63, 61));
          endcase
        end
      end
      send_time(t);
    end
  endtask

  initial begin
    rst = 1'b1;
    din_bus.valid = 1'b0;
    din_bus.years_since_1900 = '0;
    din_bus.month_index = '0;
    din_bus.day_value = '0;
    din_bus.hour_value = '0;
    din_bus.minute_value = '0;
    din_bus.second_value = '0;
    din_bus.given_weekday = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_field_extremes();
    test_calendar_rules();
    drain_results();
    test_random_times(180);
    // long stretch with both sides streaming
    gaps_on = 1'b0;
    test_random_times(150);
    gaps_on = 1'b1;
    drain_results();
    test_random_times(170);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_verdicts.size() == 0) begin
      $display("date_time_validator_weekday_core_test OK");
    end else begin
      $display("date_time_validator_weekday_core_test NOT OK");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/dtv_pkg.sv
rtl/core/dtv_in_if.sv
rtl/core/dtv_out_if.sv
rtl/core/date_time_validator_weekday_core.sv
verif/date_time_validator_weekday_core_test.sv
